[rtl/core/abdd_pkg.sv]
// ----------------------------------------------------------------------------
// Adaptive baseline deflection detector: shared definitions
// Widths, reset values, register indexes and the types that pass between the
// front end, the request queue and the back end.
// ----------------------------------------------------------------------------
package abdd_pkg;

  localparam int CHANNELS      = 6;
  localparam int CH_IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CHANNEL_W     = 3;
  localparam int SAMPLE_W      = 12;
  localparam int FRAC_W        = 8;
  localparam int Q_W           = SAMPLE_W + FRAC_W;
  localparam int TIME_W        = 32;
  localparam int ALPHA_W       = 9;
  localparam int THRESH_W      = 12;
  localparam int COOLDOWN_W    = 16;
  localparam int SCORE_W       = 10;
  localparam int SCORE_ENTRIES = 6;
  localparam int SCORE_TABLE_W = SCORE_W * SCORE_ENTRIES;
  localparam int CFG_DATA_W    = SCORE_TABLE_W;
  localparam int CFG_IDX_W     = 3;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [Q_W-1:0]           BASE_RESET     = Q_W'(2048 << FRAC_W);
  localparam logic [ALPHA_W-1:0]       ALPHA_MAX      = ALPHA_W'(256);
  localparam logic [THRESH_W-1:0]      THRESH_RESET   = THRESH_W'(80);
  localparam logic [COOLDOWN_W-1:0]    COOLDOWN_RESET = COOLDOWN_W'(500);
  localparam logic [ALPHA_W-1:0]       ALPHA_N_RESET  = ALPHA_W'(26);
  localparam logic [ALPHA_W-1:0]       ALPHA_F_RESET  = ALPHA_W'(77);
  localparam logic [SCORE_TABLE_W-1:0] SCORE_RESET    =
    {10'd300, 10'd300, 10'd200, 10'd200, 10'd100, 10'd100};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD   = 3'd0,
    REG_COOLDOWN    = 3'd1,
    REG_ALPHA_NORM  = 3'd2,
    REG_ALPHA_FAST  = 3'd3,
    REG_SCORE_TABLE = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_RESET  = 1'b1
  } op_t;

  typedef struct packed {
    logic [THRESH_W-1:0]      threshold;
    logic [COOLDOWN_W-1:0]    cooldown;
    logic [ALPHA_W-1:0]       alpha_normal;
    logic [ALPHA_W-1:0]       alpha_fast;
    logic [SCORE_TABLE_W-1:0] score_table;
  } cfg_t;

  // One classified request as it waits between front and back end.
  typedef struct packed {
    op_t                 op;
    logic [CH_IDX_W-1:0] idx;
    logic [SAMPLE_W-1:0] sample_x;
    logic [SAMPLE_W-1:0] sample_y;
    logic [TIME_W-1:0]   now_ms;
    logic [ALPHA_W-1:0]  alpha;
  } req_t;

endpackage

[rtl/core/abdd_if.sv]
// ----------------------------------------------------------------------------
// Adaptive baseline deflection detector: channel interfaces
// Valid/ready channels for incoming requests and outgoing hit results.
// ----------------------------------------------------------------------------
interface abdd_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic [abdd_pkg::CHANNEL_W-1:0]     channel;
  logic [abdd_pkg::SAMPLE_W-1:0]      sample_x;
  logic [abdd_pkg::SAMPLE_W-1:0]      sample_y;
  logic [abdd_pkg::TIME_W-1:0]        now_ms;
  logic                               fast_track;

  modport source (output valid, opcode, channel, sample_x, sample_y, now_ms, fast_track,
                  input ready);
  modport sink   (input valid, opcode, channel, sample_x, sample_y, now_ms, fast_track,
                  output ready);
endinterface

interface abdd_out_if;
  logic                           valid;
  logic                           ready;
  logic [abdd_pkg::CHANNEL_W-1:0] hit_channel;
  logic [abdd_pkg::SCORE_W-1:0]   hit_score;

  modport source (output valid, hit_channel, hit_score, input ready);
  modport sink   (input valid, hit_channel, hit_score, output ready);
endinterface

[rtl/core/abdd_front.sv]
// ----------------------------------------------------------------------------
// Adaptive baseline deflection detector: front end
// Accepts requests, drops samples for channels that do not exist and picks
// the averaging weight, clamped to one whole.
// ----------------------------------------------------------------------------
module abdd_front (
  abdd_in_if.sink            in_req,
  input  abdd_pkg::cfg_t     cfg,
  input  logic               q_ready,
  output logic               q_push,
  output abdd_pkg::req_t     q_req
);

  logic                         is_reset;
  logic                         in_range;
  logic [abdd_pkg::ALPHA_W-1:0] alpha_sel;

  assign is_reset  = (in_req.opcode == abdd_pkg::OP_RESET);
  assign in_range  = (32'(in_req.channel) < abdd_pkg::CHANNELS);
  assign alpha_sel = in_req.fast_track ? cfg.alpha_fast : cfg.alpha_normal;

  assign in_req.ready = q_ready;
  // Samples for absent channels leave no trace, so they never enter the queue.
  assign q_push = in_req.valid && q_ready && (is_reset || in_range);

  always_comb begin
    q_req.op       = is_reset ? abdd_pkg::OP_RESET : abdd_pkg::OP_SAMPLE;
    q_req.idx      = abdd_pkg::CH_IDX_W'(in_req.channel);
    q_req.sample_x = in_req.sample_x;
    q_req.sample_y = in_req.sample_y;
    q_req.now_ms   = in_req.now_ms;
    q_req.alpha    = (alpha_sel > abdd_pkg::ALPHA_MAX) ? abdd_pkg::ALPHA_MAX : alpha_sel;
  end

endmodule

[rtl/core/abdd_queue.sv]
// ----------------------------------------------------------------------------
// Adaptive baseline deflection detector: request queue
// Short first-in first-out buffer between front and back end.
// ----------------------------------------------------------------------------
module abdd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  abdd_pkg::req_t push_req,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output abdd_pkg::req_t pop_req
);

  abdd_pkg::req_t                store_r [abdd_pkg::QUEUE_DEPTH];
  logic [abdd_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [abdd_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [abdd_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                          do_pop;

  function automatic logic [abdd_pkg::QPTR_W-1:0] ptr_inc(
    input logic [abdd_pkg::QPTR_W-1:0] p
  );
    ptr_inc = (p == abdd_pkg::QPTR_W'(abdd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = rst_n && (count_r != abdd_pkg::QCNT_W'(abdd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_req    = store_r[rd_ptr_r];
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

[rtl/core/abdd_back.sv]
// ----------------------------------------------------------------------------
// Adaptive baseline deflection detector: back end
// Holds the per-channel baselines and hit times, updates the averages,
// judges the deflection and the cooldown, and registers the hit result.
// ----------------------------------------------------------------------------
module abdd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  abdd_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  abdd_pkg::req_t   q_req,
  output logic             q_pop,
  abdd_out_if.source       out_res
);

  localparam int DIFF_W = abdd_pkg::Q_W + 1;
  localparam int PROD_W = DIFF_W + abdd_pkg::ALPHA_W + 1;

  logic [abdd_pkg::Q_W-1:0]    baseline_x_r [abdd_pkg::CHANNELS];
  logic [abdd_pkg::Q_W-1:0]    baseline_y_r [abdd_pkg::CHANNELS];
  logic [abdd_pkg::TIME_W-1:0] last_hit_r   [abdd_pkg::CHANNELS];

  logic                             out_valid_r, out_valid_nxt;
  logic [abdd_pkg::CHANNEL_W-1:0]   out_channel_r, out_channel_nxt;
  logic [abdd_pkg::SCORE_W-1:0]     out_score_r, out_score_nxt;

  logic                             fire, is_sample, hit;
  logic [abdd_pkg::Q_W-1:0]         new_x, new_y;
  logic [abdd_pkg::TIME_W-1:0]      elapsed;
  logic                             dev_x_hit, dev_y_hit;

  // One axis of the average: new = old + floor(alpha * (sample - old) / 256).
  function automatic logic [abdd_pkg::Q_W-1:0] ema_step(
    input logic [abdd_pkg::Q_W-1:0]      old,
    input logic [abdd_pkg::SAMPLE_W-1:0] smp,
    input logic [abdd_pkg::ALPHA_W-1:0]  alpha
  );
    logic signed [DIFF_W-1:0]            diff;
    logic signed [abdd_pkg::ALPHA_W:0]   alpha_s;
    logic signed [PROD_W-1:0]            prod;
    diff     = $signed({1'b0, smp, abdd_pkg::FRAC_W'(0)}) - $signed({1'b0, old});
    alpha_s  = $signed({1'b0, alpha});
    prod     = diff * alpha_s;
    ema_step = old + prod[abdd_pkg::FRAC_W +: abdd_pkg::Q_W];
  endfunction

  // Whole-unit deviation magnitude above the threshold.
  function automatic logic dev_over(
    input logic [abdd_pkg::SAMPLE_W-1:0] smp,
    input logic [abdd_pkg::Q_W-1:0]      base,
    input logic [abdd_pkg::THRESH_W-1:0] thr
  );
    logic [DIFF_W-1:0] dev;
    logic [DIFF_W-1:0] mag;
    dev      = {1'b0, smp, abdd_pkg::FRAC_W'(0)} - {1'b0, base};
    mag      = dev[DIFF_W-1] ? (~dev + 1'b1) : dev;
    dev_over = mag[DIFF_W-1:abdd_pkg::FRAC_W] > {1'b0, thr};
  endfunction

  assign q_pop     = !out_valid_r || out_res.ready;
  assign fire      = q_pop && q_valid;
  assign is_sample = (q_req.op == abdd_pkg::OP_SAMPLE);

  assign new_x     = ema_step(baseline_x_r[q_req.idx], q_req.sample_x, q_req.alpha);
  assign new_y     = ema_step(baseline_y_r[q_req.idx], q_req.sample_y, q_req.alpha);
  assign dev_x_hit = dev_over(q_req.sample_x, new_x, cfg.threshold);
  assign dev_y_hit = dev_over(q_req.sample_y, new_y, cfg.threshold);
  assign elapsed   = q_req.now_ms - last_hit_r[q_req.idx];
  assign hit       = (dev_x_hit || dev_y_hit) &&
                     (elapsed > abdd_pkg::TIME_W'(cfg.cooldown));

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_channel_nxt = out_channel_r;
    out_score_nxt   = out_score_r;
    if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire && is_sample && hit) begin
      out_valid_nxt   = 1'b1;
      out_channel_nxt = abdd_pkg::CHANNEL_W'(q_req.idx);
      out_score_nxt   = (32'(q_req.idx) < abdd_pkg::SCORE_ENTRIES) ?
                        cfg.score_table[abdd_pkg::SCORE_W * q_req.idx +: abdd_pkg::SCORE_W] :
                        '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_channel_r <= out_channel_nxt;
    out_score_r   <= out_score_nxt;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < abdd_pkg::CHANNELS; i++) begin
      if (!rst_n || (fire && !is_sample)) begin
        baseline_x_r[i] <= abdd_pkg::BASE_RESET;
        baseline_y_r[i] <= abdd_pkg::BASE_RESET;
      end else if (fire && (q_req.idx == abdd_pkg::CH_IDX_W'(i))) begin
        baseline_x_r[i] <= new_x;
        baseline_y_r[i] <= new_y;
      end
      if (!rst_n) begin
        last_hit_r[i] <= '0;
      end else if (fire && is_sample && hit && (q_req.idx == abdd_pkg::CH_IDX_W'(i))) begin
        last_hit_r[i] <= q_req.now_ms;
      end
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.hit_channel = out_channel_r;
  assign out_res.hit_score   = out_score_r;

endmodule

[rtl/core/adaptive_baseline_deflection_detector.sv]
// ----------------------------------------------------------------------------
// Adaptive baseline deflection detector
// Per-channel two-axis baseline tracking with threshold and cooldown hits.
// ----------------------------------------------------------------------------
// The detector takes one request per clock cycle, indefinitely, as long as
// results are taken when offered. A sample request is accepted by the front
// end, which discards samples for channels that do not exist and picks the
// averaging weight, and is written into a two-entry queue. The back end takes
// one request from the queue per cycle while no result waits untaken, and
// does the whole per-channel update in that cycle: one 21 by 10 bit multiply
// per axis for the exponential average, a deviation compare against the
// threshold and a 32-bit wrapping time compare against the cooldown. The back
// end thus sets the rate. A hit passes through the queue storage and then the
// output register before it is presented; further requests keep flowing into
// the queue while a result waits, and the input only stalls once the queue
// is full. A baseline reset request travels the same path, so it takes
// effect in order with the samples around it and produces no result.
// Configuration registers are written through the plain write port and
// should only be changed while no request is in flight.
// ----------------------------------------------------------------------------
module adaptive_baseline_deflection_detector (
  input  logic                                clk,
  input  logic                                rst_n,
  abdd_in_if.sink                             in_req,
  abdd_out_if.source                          out_res,
  input  logic                                cfg_we,
  input  logic [abdd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [abdd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  abdd_pkg::cfg_t cfg_r, cfg_nxt;

  logic           q_push, q_ready, q_pop, q_valid;
  abdd_pkg::req_t push_req, pop_req;

  // Register file: each write takes the low bits of the write data.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (abdd_pkg::cfg_reg_t'(cfg_index))
        abdd_pkg::REG_THRESHOLD:   cfg_nxt.threshold    = cfg_wdata[abdd_pkg::THRESH_W-1:0];
        abdd_pkg::REG_COOLDOWN:    cfg_nxt.cooldown     = cfg_wdata[abdd_pkg::COOLDOWN_W-1:0];
        abdd_pkg::REG_ALPHA_NORM:  cfg_nxt.alpha_normal = cfg_wdata[abdd_pkg::ALPHA_W-1:0];
        abdd_pkg::REG_ALPHA_FAST:  cfg_nxt.alpha_fast   = cfg_wdata[abdd_pkg::ALPHA_W-1:0];
        abdd_pkg::REG_SCORE_TABLE: cfg_nxt.score_table  =
                                     cfg_wdata[abdd_pkg::SCORE_TABLE_W-1:0];
        default: begin
          // Writes to indexes beyond the register list are ignored.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold    <= abdd_pkg::THRESH_RESET;
      cfg_r.cooldown     <= abdd_pkg::COOLDOWN_RESET;
      cfg_r.alpha_normal <= abdd_pkg::ALPHA_N_RESET;
      cfg_r.alpha_fast   <= abdd_pkg::ALPHA_F_RESET;
      cfg_r.score_table  <= abdd_pkg::SCORE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: accept and classify.
  abdd_front u_front (
    .in_req  (in_req),
    .cfg     (cfg_r),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_req   (push_req)
  );

  // Decoupling queue, so that front and back end stall independently.
  abdd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_req   (push_req),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_req    (pop_req)
  );

  // Back end: baseline update, hit decision and result register.
  abdd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_req   (pop_req),
    .q_pop   (q_pop),
    .out_res (out_res)
  );

endmodule

[rtl/core/abdd_checker.sv]
// ----------------------------------------------------------------------------
// Adaptive baseline deflection detector: port checker
// Concurrent assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module abdd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [abdd_pkg::CHANNEL_W-1:0] hit_channel,
  input logic [abdd_pkg::SCORE_W-1:0]   hit_score
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(hit_channel) && $stable(hit_score))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(hit_channel) < abdd_pkg::CHANNELS))
    else $error("hit reported for a channel that does not exist");

endmodule

bind adaptive_baseline_deflection_detector abdd_checker u_abdd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .hit_channel (out_res.hit_channel),
  .hit_score   (out_res.hit_score)
);

[sim/tb_adaptive_baseline_deflection_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the adaptive baseline deflection detector
// Drives sample and baseline-reset requests through the input channel and
// predicts every hit with an independent model of the per-channel baselines,
// threshold and cooldown. Each hit taken from the result channel is checked
// against the oldest predicted hit. Both channels idle at random, and the
// configuration is changed between phases while the detector is idle.
// ----------------------------------------------------------------------------
module tb_adaptive_baseline_deflection_detector;
  import abdd_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 10;
  // The queue holds two requests and a hit leaves through the queue and then the
  // output register, so this drain covers anything still in flight.
  localparam int DRAIN_CYCLES    = 8;
  localparam int ITEMS_PER_PHASE = 275;
  localparam int REGIMES         = 5;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int MAX_REPORTS     = 10;

  // One predicted or observed hit.
  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [SCORE_W-1:0]   score;
  } hit_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  abdd_in_if  in_req_if ();
  abdd_out_if out_res_if ();

  adaptive_baseline_deflection_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req_if),
    .out_res   (out_res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: our own copy of the baselines, hit times and registers.
  logic [Q_W-1:0]    track_x [CHANNELS];
  logic [Q_W-1:0]    track_y [CHANNELS];
  logic [TIME_W-1:0] last_hit [CHANNELS];
  cfg_t              cfg_shadow;

  // Hits predicted but not yet seen on the result channel, oldest first.
  hit_t              pending_hits [$];
  hit_t              oldest_hit;

  int unsigned       failures = 0;
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;
  bit                idle_enable;
  int unsigned       send_quiet;
  int unsigned       recv_quiet = 0;
  int unsigned       recv_stall = 0;
  logic [TIME_W-1:0] clock_ms;

  always #CLK_HALF clk = ~clk;

  // The run is abandoned if it goes on far longer than the slowest legal run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Exponential average in Q12.8: the weighted sum is floored by the shift,
  // so it can never leave the 20-bit range.
  function automatic logic [Q_W-1:0] ema_track(logic [Q_W-1:0] old,
                                               logic [SAMPLE_W-1:0] sample,
                                               logic [ALPHA_W-1:0] alpha);
    logic [39:0] acc;
    acc = 40'(alpha) * (40'(sample) << FRAC_W) + 40'(ALPHA_MAX - alpha) * 40'(old);
    return acc[FRAC_W +: Q_W];
  endfunction

  // Magnitude of the sample's distance from the baseline, with the fraction
  // dropped, which truncates toward zero in either direction.
  function automatic logic [SAMPLE_W-1:0] deflection_mag(logic [SAMPLE_W-1:0] sample,
                                                         logic [Q_W-1:0] base);
    logic [Q_W-1:0] scaled;
    logic [Q_W-1:0] mag;
    scaled = {sample, {FRAC_W{1'b0}}};
    mag    = (scaled >= base) ? scaled - base : base - scaled;
    return mag[Q_W-1 -: SAMPLE_W];
  endfunction

  // Advances the predictor by one accepted request and queues a hit when one
  // is due.
  function automatic void predict_hit(op_t op, logic [CHANNEL_W-1:0] ch,
                                      logic [SAMPLE_W-1:0] sx, logic [SAMPLE_W-1:0] sy,
                                      logic [TIME_W-1:0] now, logic fast);
    logic [ALPHA_W-1:0]  alpha;
    logic [SAMPLE_W-1:0] dx;
    logic [SAMPLE_W-1:0] dy;
    logic [TIME_W-1:0]   elapsed;
    int                  idx;
    hit_t                hit;
    if (op == OP_RESET) begin
      foreach (track_x[i]) begin
        track_x[i] = BASE_RESET;
        track_y[i] = BASE_RESET;
      end
      return;
    end
    // Samples for channels that do not exist leave everything untouched.
    if (ch >= CHANNELS) return;
    idx   = ch;
    alpha = fast ? cfg_shadow.alpha_fast : cfg_shadow.alpha_normal;
    if (alpha > ALPHA_MAX) alpha = ALPHA_MAX;
    track_x[idx] = ema_track(track_x[idx], sx, alpha);
    track_y[idx] = ema_track(track_y[idx], sy, alpha);
    dx      = deflection_mag(sx, track_x[idx]);
    dy      = deflection_mag(sy, track_y[idx]);
    // The elapsed time wraps with the millisecond counter.
    elapsed = now - last_hit[idx];
    if ((dx > cfg_shadow.threshold || dy > cfg_shadow.threshold) &&
        elapsed > TIME_W'(cfg_shadow.cooldown)) begin
      last_hit[idx] = now;
      hit.channel   = ch;
      hit.score     = cfg_shadow.score_table[SCORE_W*idx +: SCORE_W];
      pending_hits.push_back(hit);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: checks every hit and stalls in random bursts.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_res_if.ready <= 1'b0;
    end else begin
      if (out_res_if.valid && out_res_if.ready) begin
        if (pending_hits.size() == 0) begin
          failures++;
          if (mismatches < MAX_REPORTS)
            $display("Unexpected hit: channel %0d score %0d",
                     out_res_if.hit_channel, out_res_if.hit_score);
          mismatches++;
        end else begin
          oldest_hit = pending_hits.pop_front();
          if (out_res_if.hit_channel !== oldest_hit.channel ||
              out_res_if.hit_score !== oldest_hit.score) begin
            failures++;
            if (mismatches < MAX_REPORTS)
              $display("Hit mismatch: channel exp %0d got %0d, score exp %0d got %0d",
                       oldest_hit.channel, out_res_if.hit_channel,
                       oldest_hit.score, out_res_if.hit_score);
            mismatches++;
          end
        end
      end
      // Stall bursts alternate with quiet stretches where ready stays high.
      if (recv_stall > 0) begin
        recv_stall--;
        out_res_if.ready <= 1'b0;
      end else if (recv_quiet > 0) begin
        recv_quiet--;
        out_res_if.ready <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        recv_stall = $urandom_range(0, 17);
        out_res_if.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 29) == 0) recv_quiet = $urandom_range(20, 60);
        out_res_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Writes one register and leaves the write enable high, so that writes can
  // follow each other; the caller lowers it after the last one. Only called
  // while nothing is in flight, so the shadow copy can follow at once.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_THRESHOLD:   cfg_shadow.threshold    = value[THRESH_W-1:0];
      REG_COOLDOWN:    cfg_shadow.cooldown     = value[COOLDOWN_W-1:0];
      REG_ALPHA_NORM:  cfg_shadow.alpha_normal = value[ALPHA_W-1:0];
      REG_ALPHA_FAST:  cfg_shadow.alpha_fast   = value[ALPHA_W-1:0];
      REG_SCORE_TABLE: cfg_shadow.score_table  = value[SCORE_TABLE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [THRESH_W-1:0] thr, logic [COOLDOWN_W-1:0] cooldown,
                            logic [ALPHA_W-1:0] a_norm, logic [ALPHA_W-1:0] a_fast,
                            logic [SCORE_TABLE_W-1:0] scores);
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_COOLDOWN, CFG_DATA_W'(cooldown));
    write_reg(REG_ALPHA_NORM, CFG_DATA_W'(a_norm));
    write_reg(REG_ALPHA_FAST, CFG_DATA_W'(a_fast));
    write_reg(REG_SCORE_TABLE, CFG_DATA_W'(scores));
    cfg_we <= 1'b0;
  endtask

  // Presents one request and returns at the edge where it is accepted. Valid
  // is left high, so a following request goes out back to back; it is only
  // lowered when a gap is taken or the sender waits for the detector.
  task automatic send_request(op_t op, logic [CHANNEL_W-1:0] ch,
                              logic [SAMPLE_W-1:0] sx, logic [SAMPLE_W-1:0] sy,
                              logic [TIME_W-1:0] now, logic fast);
    int unsigned gap;
    if (send_quiet > 0) begin
      send_quiet--;
    end else if (idle_enable && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 18);
      in_req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else if ($urandom_range(0, 29) == 0) begin
      send_quiet = $urandom_range(20, 60);
    end
    in_req_if.valid      <= 1'b1;
    in_req_if.opcode     <= op;
    in_req_if.channel    <= ch;
    in_req_if.sample_x   <= sx;
    in_req_if.sample_y   <= sy;
    in_req_if.now_ms     <= now;
    in_req_if.fast_track <= fast;
    do @(posedge clk); while (!in_req_if.ready);
    predict_hit(op, ch, sx, sy, now, fast);
  endtask

  // Holds off new requests until every predicted hit has been taken, then
  // lets requests that cause no hit leave the pipeline as well.
  task automatic wait_idle();
    in_req_if.valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Half the samples sit close to mid scale, where hits depend finely on the
  // threshold; the other half span the whole converter range.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(0, 1) == 0) return SAMPLE_W'($urandom);
    return SAMPLE_W'(2048 + $urandom_range(0, 240) - 120);
  endfunction

  // A random request: mostly samples for real channels with time moving
  // forward, with the odd baseline reset, missing channel or time jump.
  task automatic random_request();
    op_t                  op;
    logic [CHANNEL_W-1:0] ch;
    op = ($urandom_range(0, 31) == 0) ? OP_RESET : OP_SAMPLE;
    if ($urandom_range(0, 9) == 0)
      ch = CHANNEL_W'($urandom_range(CHANNELS, 7));
    else
      ch = CHANNEL_W'($urandom_range(0, CHANNELS - 1));
    if ($urandom_range(0, 49) == 0)
      clock_ms = $urandom;
    else
      clock_ms += $urandom_range(0, 400);
    send_request(op, ch, pick_sample(), pick_sample(), clock_ms, 1'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset configuration: full-scale deflections on both edge channels, one
  // axis at a time, missing channels, a baseline reset and a quiet stick.
  task automatic test_basic_detection();
    send_request(OP_SAMPLE, 3'd0, 12'd4095, 12'd0, 32'd1000, 1'b0);
    send_request(OP_SAMPLE, 3'd5, 12'd0, 12'd4095, 32'd1000, 1'b1);
    send_request(OP_SAMPLE, 3'd6, 12'd4095, 12'd4095, 32'd1200, 1'b0);
    send_request(OP_SAMPLE, 3'd7, 12'd0, 12'd0, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_RESET, 3'd7, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b1);
    send_request(OP_SAMPLE, 3'd3, 12'd2048, 12'd2048, 32'd2000, 1'b0);
    send_request(OP_SAMPLE, 3'd1, 12'd2048, 12'd4095, 32'd2000, 1'b1);
  endtask

  // Cooldown across the wrap of the millisecond counter: exactly the cooldown
  // is not enough, one more millisecond is.
  task automatic test_cooldown_wrap();
    send_request(OP_SAMPLE, 3'd2, 12'd4095, 12'd4095, 32'hFFFF_FF00, 1'b0);
    send_request(OP_SAMPLE, 3'd2, 12'd0, 12'd0, 32'h0000_00F4, 1'b0);
    send_request(OP_SAMPLE, 3'd2, 12'd0, 12'd0, 32'h0000_00F5, 1'b0);
    send_request(OP_SAMPLE, 3'd2, 12'd4095, 12'd4095, 32'h0000_01BD, 1'b0);
    send_request(OP_SAMPLE, 3'd2, 12'd4095, 12'd4095, 32'h0000_02EA, 1'b0);
  endtask

  // With both weights at zero the baselines stay at mid scale, so the
  // strict threshold compare can be hit exactly from either side, and a zero
  // cooldown still refuses a second hit at the same millisecond. A weight
  // above 256 then behaves as 256, leaving no deviation at all.
  task automatic test_threshold_edges();
    wait_idle();
    set_config(12'd80, 16'd0, 9'd0, 9'd0, SCORE_RESET);
    send_request(OP_RESET, 3'd0, 12'd0, 12'd0, 32'd0, 1'b0);
    send_request(OP_SAMPLE, 3'd4, 12'd2128, 12'd2048, 32'd5000, 1'b0);
    send_request(OP_SAMPLE, 3'd4, 12'd2129, 12'd2048, 32'd5001, 1'b0);
    send_request(OP_SAMPLE, 3'd4, 12'd1967, 12'd2048, 32'd5001, 1'b0);
    send_request(OP_SAMPLE, 3'd4, 12'd1967, 12'd2048, 32'd5002, 1'b0);
    send_request(OP_SAMPLE, 3'd4, 12'd1968, 12'd2048, 32'd5003, 1'b0);
    send_request(OP_SAMPLE, 3'd4, 12'd2048, 12'd2129, 32'd5004, 1'b1);
    wait_idle();
    write_reg(REG_THRESHOLD, CFG_DATA_W'(0));
    write_reg(REG_ALPHA_FAST, CFG_DATA_W'(511));
    cfg_we <= 1'b0;
    send_request(OP_SAMPLE, 3'd4, 12'd4095, 12'd0, 32'd5010, 1'b1);
  endtask

  // Random requests under a series of settings, extremes among them. Halfway
  // through each phase the sender waits for every outstanding hit.
  task automatic test_random_regimes();
    for (int p = 0; p < REGIMES; p++) begin
      wait_idle();
      case (p)
        0: set_config(THRESH_RESET, COOLDOWN_RESET, ALPHA_N_RESET, ALPHA_F_RESET,
                      SCORE_RESET);
        1: set_config(12'd0, 16'd0, 9'd0, 9'd256, {SCORE_TABLE_W{1'b1}});
        2: set_config(12'd4095, 16'd65535, 9'd511, 9'd300, '0);
        3: set_config(THRESH_W'($urandom_range(0, 300)), COOLDOWN_W'($urandom_range(0, 2000)),
                      ALPHA_W'($urandom), ALPHA_W'($urandom),
                      SCORE_TABLE_W'({$urandom, $urandom}));
        default: set_config(THRESH_W'($urandom), COOLDOWN_W'($urandom),
                            ALPHA_W'($urandom_range(1, 255)),
                            ALPHA_W'($urandom_range(1, 255)),
                            SCORE_TABLE_W'({$urandom, $urandom}));
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) wait_idle();
        random_request();
      end
    end
  endtask

  // Last stretch at full rate on both sides, with no idling anywhere.
  task automatic test_steady_stream();
    wait_idle();
    idle_enable = 1'b0;
    set_config(12'd40, 16'd150, ALPHA_N_RESET, ALPHA_F_RESET,
               SCORE_TABLE_W'({$urandom, $urandom}));
    for (int n = 0; n < ITEMS_PER_PHASE; n++) random_request();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_THRESHOLD;
    cfg_wdata            <= '0;
    in_req_if.valid      <= 1'b0;
    in_req_if.opcode     <= OP_SAMPLE;
    in_req_if.channel    <= '0;
    in_req_if.sample_x   <= '0;
    in_req_if.sample_y   <= '0;
    in_req_if.now_ms     <= '0;
    in_req_if.fast_track <= 1'b0;
    idle_enable = 1'b1;
    send_quiet  = 0;
    clock_ms    = 32'h0000_4000;
    // The predictor starts from the same state as the detector after reset.
    cfg_shadow.threshold    = THRESH_RESET;
    cfg_shadow.cooldown     = COOLDOWN_RESET;
    cfg_shadow.alpha_normal = ALPHA_N_RESET;
    cfg_shadow.alpha_fast   = ALPHA_F_RESET;
    cfg_shadow.score_table  = SCORE_RESET;
    foreach (track_x[i]) begin
      track_x[i]  = BASE_RESET;
      track_y[i]  = BASE_RESET;
      last_hit[i] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_detection();
    test_cooldown_wrap();
    test_threshold_edges();
    test_random_regimes();
    test_steady_stream();

    // A hit that never arrives keeps this wait going until the watchdog ends
    // the run.
    wait_idle();
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/abdd_pkg.sv
rtl/core/abdd_if.sv
rtl/core/abdd_front.sv
rtl/core/abdd_queue.sv
rtl/core/abdd_back.sv
rtl/core/adaptive_baseline_deflection_detector.sv
rtl/core/abdd_checker.sv
sim/tb_adaptive_baseline_deflection_detector.sv
